[rtl/mme_pkg.sv]
package mme_pkg;

  localparam int unsigned KeyWidth = 32;
  localparam int unsigned DataWidth = (KeyWidth > 32) ? 64 : 32;
  localparam int unsigned AddrWidth = (KeyWidth > 32) ? 4 : 3;
  localparam int unsigned CntWidth = $clog2(KeyWidth);

  typedef logic [KeyWidth-1:0] key_t;

  // Register index as decoded from the byte address.
  typedef enum logic {
    REG_EXPONENT = 1'b0,
    REG_MODULUS  = 1'b1
  } reg_idx_e;

  localparam key_t ExponentReset = key_t'(0);
  localparam key_t ModulusReset  = key_t'(1);

endpackage

[rtl/modular_exponentiation.sv]
// Channel   Handshake              Payload
// -------   --------------------   ----------------
// input     start / busy           message_value_i
// result    done_o (strobe)        result_value_o
// config    psel/penable/pwrite    paddr, pwdata, prdata
//
// One word at a time. A message is first reduced modulo the modulus, then the
// exponent is scanned over all of its bits, MSB first: one square per bit and
// one extra multiply per set bit. Each modular multiply is done by a bit-serial
// unit. A zero exponent returns 1 without any multiply.
// Reset is asynchronous and active low. The receiver cannot stall results.
module modular_exponentiation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [mme_pkg::KeyWidth-1:0]   message_value_i,
  output logic                           done_o,
  output logic [mme_pkg::KeyWidth-1:0]   result_value_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mme_pkg::AddrWidth-1:0]  paddr,
  input  logic [mme_pkg::DataWidth-1:0]  pwdata,
  output logic [mme_pkg::DataWidth-1:0]  prdata,
  output logic                           pready
);
  import mme_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_SQUARE = 5'b00100,
    S_MULT   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  key_t                exponent;
  key_t                modulus;
  key_t                m_eff;
  key_t                one;
  key_t                m_q, m_d;
  key_t                acc_q, acc_d;
  key_t                base_q, base_d;
  key_t                exp_q, exp_d;
  logic [CntWidth-1:0] bit_q, bit_d;

  logic mul_start;
  key_t mul_a;
  key_t mul_b;
  key_t mul_m;
  logic mul_done;
  key_t mul_p;

  mme_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .exponent_o (exponent),
    .modulus_o  (modulus)
  );

  mme_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (mul_m),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // A zero modulus behaves as a modulus of one.
  assign m_eff = (modulus == '0) ? key_t'(1) : modulus;
  assign one   = (m_eff == key_t'(1)) ? '0 : key_t'(1);

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    base_d    = base_q;
    exp_d     = exp_q;
    bit_d     = bit_q;
    m_d       = m_q;
    mul_start = 1'b0;
    mul_a     = acc_q;
    mul_b     = acc_q;
    mul_m     = m_q;
    unique case (state_q) inside
      S_IDLE: begin
        if (start) begin
          if (exponent == '0) begin
            acc_d   = key_t'(1);
            state_d = S_DONE;
          end else begin
            // The message is reduced by multiplying it with 1 mod m.
            m_d       = m_eff;
            acc_d     = one;
            exp_d     = exponent;
            mul_start = 1'b1;
            mul_a     = one;
            mul_b     = message_value_i;
            mul_m     = m_eff;
            state_d   = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (mul_done) begin
          base_d    = mul_p;
          bit_d     = CntWidth'(KeyWidth - 1);
          mul_start = 1'b1;
          state_d   = S_SQUARE;
        end
      end
      S_SQUARE, S_MULT: begin
        if (mul_done) begin
          acc_d = mul_p;
          if ((state_q == S_SQUARE) && exp_q[KeyWidth-1]) begin
            mul_start = 1'b1;
            mul_a     = base_q;
            mul_b     = mul_p;
            state_d   = S_MULT;
          end else begin
            exp_d = {exp_q[KeyWidth-2:0], 1'b0};
            if (bit_q == '0) begin
              state_d = S_DONE;
            end else begin
              bit_d     = bit_q - CntWidth'(1);
              mul_start = 1'b1;
              mul_a     = mul_p;
              mul_b     = mul_p;
              state_d   = S_SQUARE;
            end
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    m_q    <= m_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = (state_q == S_DONE);
  assign result_value_o = acc_q;

endmodule

[rtl/mme_regs.sv]
module mme_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mme_pkg::AddrWidth-1:0]  paddr,
  input  logic [mme_pkg::DataWidth-1:0]  pwdata,
  output logic [mme_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  output mme_pkg::key_t                  exponent_o,
  output mme_pkg::key_t                  modulus_o
);
  import mme_pkg::*;

  key_t     exponent_q;
  key_t     modulus_q;
  reg_idx_e idx;
  logic     wr_en;

  // Only the register-select bit of the byte address is decoded.
  assign idx   = reg_idx_e'(paddr[AddrWidth-1]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= ExponentReset;
      modulus_q  <= ModulusReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_EXPONENT: exponent_q <= pwdata[KeyWidth-1:0];
        REG_MODULUS:  modulus_q  <= pwdata[KeyWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_EXPONENT: prdata = DataWidth'(exponent_q);
      REG_MODULUS:  prdata = DataWidth'(modulus_q);
      default:      prdata = '0;
    endcase
  end

  assign exponent_o = exponent_q;
  assign modulus_o  = modulus_q;

endmodule

[rtl/mme_modmul.sv]
module mme_modmul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mme_pkg::key_t a_i,
  input  mme_pkg::key_t b_i,
  input  mme_pkg::key_t m_i,
  output logic          done_o,
  output mme_pkg::key_t p_o
);
  import mme_pkg::*;

  localparam int unsigned SumWidth = KeyWidth + 2;

  logic                run_q;
  logic                done_q;
  logic [CntWidth-1:0] cnt_q;
  key_t                a_q;
  key_t                b_q;
  key_t                m_q;
  key_t                acc_q;
  key_t                acc_d;

  logic [SumWidth-1:0] sum;
  logic [SumWidth-1:0] m1;
  logic [SumWidth-1:0] m2;
  key_t                addend;

  // Interleaved multiply: acc = 2*acc + bit*a, then bring it back below m.
  // With acc < m and a < m the sum stays below 3m, so at most 2m is removed.
  always_comb begin
    addend = b_q[KeyWidth-1] ? a_q : '0;
    sum    = {1'b0, acc_q, 1'b0} + {2'b00, addend};
    m1     = {2'b00, m_q};
    m2     = {1'b0, m_q, 1'b0};
    if (sum >= m2) begin
      acc_d = key_t'(sum - m2);
    end else if (sum >= m1) begin
      acc_d = key_t'(sum - m1);
    end else begin
      acc_d = sum[KeyWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntWidth'(KeyWidth - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntWidth'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[KeyWidth-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule
